// File: src/pstt_pkg.sv
`default_nettype none
package pstt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int ACT_W          = 2;
    localparam int ID_W           = 4;
    localparam int PERIOD_W       = 16;
    localparam int TICK_W         = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_ARM  = 2'd1,
        ACT_POLL = 2'd2
    } t_action;

    // table write from the evaluation stage; armed is always set by a write
    typedef struct packed {
        logic                en;
        logic [PERIOD_W-1:0] period;
        logic [TICK_W-1:0]   deadline;
    } t_tbl_wr;

    // entry as read out of the table
    typedef struct packed {
        logic                armed;
        logic [PERIOD_W-1:0] period;
        logic [TICK_W-1:0]   deadline;
    } t_tbl_rd;

endpackage
`default_nettype wire

// File: src/pstt_table.sv
`default_nettype none
module pstt_table
    import pstt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int IDX_W      = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_tbl_rd               o_rd,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_tbl_wr          i_wr
);

    logic [NUM_TIMERS-1:0] r_armed;
    logic [PERIOD_W-1:0]   r_period_mem   [NUM_TIMERS];
    logic [TICK_W-1:0]     r_deadline_mem [NUM_TIMERS];
    t_tbl_rd               r_rd;
    logic                  fwd;

    assign fwd  = i_wr.en && (i_wr_addr == i_rd_addr);
    assign o_rd = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
        end else if (i_wr.en) begin
            r_armed[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_period_mem[i_wr_addr]   <= i_wr.period;
            r_deadline_mem[i_wr_addr] <= i_wr.deadline;
        end
    end

    // registered read; a write to the same entry in this cycle bypasses the array
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (fwd) begin
                r_rd.armed    <= 1'b1;
                r_rd.period   <= i_wr.period;
                r_rd.deadline <= i_wr.deadline;
            end else begin
                r_rd.armed    <= r_armed[i_rd_addr];
                r_rd.period   <= r_period_mem[i_rd_addr];
                r_rd.deadline <= r_deadline_mem[i_rd_addr];
            end
        end
    end

endmodule
`default_nettype wire

// File: src/pstt_eval.sv
`default_nettype none
module pstt_eval
    import pstt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [ID_W-1:0]     i_timer_id,
    input  wire logic [PERIOD_W-1:0] i_delay_ms,
    input  wire logic [TICK_W-1:0]   i_tick,
    input  wire t_tbl_rd             i_rd,
    output logic                     o_expired,
    output logic                     o_tick_inc,
    output t_tbl_wr                  o_wr
);

    logic in_range;
    logic due;

    assign in_range = (32'(i_timer_id) < NUM_TIMERS);
    // plain unsigned compare, not wrap-safe
    assign due      = in_range && i_rd.armed && (i_tick >= i_rd.deadline);

    always_comb begin
        o_expired   = 1'b0;
        o_tick_inc  = 1'b0;
        o_wr.en     = 1'b0;
        o_wr.period = i_delay_ms;
        case (t_action'(i_action))
            ACT_TICK: begin
                o_tick_inc = 1'b1;
            end
            ACT_ARM: begin
                o_wr.en = in_range;
            end
            ACT_POLL: begin
                o_expired   = due;
                o_wr.en     = due;
                o_wr.period = i_rd.period;
            end
            default: begin
            end
        endcase
        o_wr.deadline = i_tick + TICK_W'(o_wr.period);
    end

endmodule
`default_nettype wire

// File: src/periodic_soft_timer_table_top.sv
// An accepted item passes the evaluation stage register, then the output register.
// Throughput: one item per cycle but for output stalls; the table read at accept
// and its write when it leaves evaluation, with a bypass, carry item dependency.
// Reset (synchronous, active low) clears the tick count, all armed bits and the
// stage valids; period and deadline entries are only read once armed.
`default_nettype none
module periodic_soft_timer_table_top
    import pstt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [ID_W-1:0]     i_timer_id,
    input  wire logic [PERIOD_W-1:0] i_delay_ms,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_expired
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic                r_s1_valid;
    logic [ACT_W-1:0]    r_action;
    logic [ID_W-1:0]     r_timer_id;
    logic [PERIOD_W-1:0] r_delay_ms;
    logic [TICK_W-1:0]   r_tick;
    logic                r_out_valid;
    logic                r_expired;

    logic    out_free;
    logic    in_accept;
    logic    s1_fire;
    t_tbl_rd rd;
    t_tbl_wr wr;
    logic    ev_expired;
    logic    ev_tick_inc;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign s1_fire     = r_s1_valid && out_free;
    assign o_out_valid = r_out_valid;
    assign o_expired   = r_expired;

    pstt_table #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (IDX_W'(i_timer_id)),
        .o_rd      (rd),
        .i_wr_addr (IDX_W'(r_timer_id)),
        .i_wr      (wr)
    );

    t_tbl_wr ev_wr;

    pstt_eval #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_eval (
        .i_action   (r_action),
        .i_timer_id (r_timer_id),
        .i_delay_ms (r_delay_ms),
        .i_tick     (r_tick),
        .i_rd       (rd),
        .o_expired  (ev_expired),
        .o_tick_inc (ev_tick_inc),
        .o_wr       (ev_wr)
    );

    // state changes only when the item leaves the evaluation stage
    always_comb begin
        wr    = ev_wr;
        wr.en = ev_wr.en && s1_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire && ev_tick_inc) begin
                r_tick <= r_tick + TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action   <= i_action;
            r_timer_id <= i_timer_id;
            r_delay_ms <= i_delay_ms;
        end
        if (s1_fire) begin
            r_expired <= ev_expired;
        end
    end

`ifndef NO_ASSERTIONS
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && ev_tick_inc) |=> (r_tick == $past(r_tick) + TICK_W'(1)))
        else $error("tick count did not advance by one");

    a_expire_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && ev_expired) |-> (rd.armed && wr.en))
        else $error("expiry without an armed entry or re-arm write");

    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_fire && ev_tick_inc) |=> $stable(r_tick))
        else $error("tick count changed without a tick item");
`endif

endmodule
`default_nettype wire

// File: verif/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pstt_pkg::*;

    localparam int NUM_TIMERS = NUM_TIMERS_DEF;
    localparam int IDLE_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  timer_id;
        logic             expired;
    } t_due;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [ACT_W-1:0]    i_action = '0;
    logic [ID_W-1:0]     i_timer_id = '0;
    logic [PERIOD_W-1:0] i_delay_ms = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_expired;

    // timer table as the testbench sees it
    logic [TICK_W-1:0]   tick_now;
    logic                armed_tbl    [NUM_TIMERS];
    logic [PERIOD_W-1:0] period_tbl   [NUM_TIMERS];
    logic [TICK_W-1:0]   deadline_tbl [NUM_TIMERS];

    t_due due_q[$];
    int   errors = 0;
    int   results_seen = 0;
    int   stall_drawn_at = 0;
    int   rx_wait = 0;
    int   idle_run = 0;
    bit   no_gaps = 1'b0;

    periodic_soft_timer_table_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_timer_id  (i_timer_id),
        .i_delay_ms  (i_delay_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_expired   (o_expired)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic clear_timers();
        tick_now = '0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            armed_tbl[k]    = 1'b0;
            period_tbl[k]   = '0;
            deadline_tbl[k] = '0;
        end
    endtask

    // applies one item to the table, returns whether a poll fired
    function automatic logic advance_timers(input logic [ACT_W-1:0] act,
                                            input logic [ID_W-1:0] id,
                                            input logic [PERIOD_W-1:0] dly);
        logic fired;
        fired = 1'b0;
        case (act)
            ACT_TICK: tick_now = tick_now + TICK_W'(1);
            ACT_ARM: begin
                if (int'(id) < NUM_TIMERS) begin
                    period_tbl[id]   = dly;
                    armed_tbl[id]    = 1'b1;
                    deadline_tbl[id] = tick_now + TICK_W'(dly);
                end
            end
            ACT_POLL: begin
                // plain unsigned compare, not wrap-safe
                if (int'(id) < NUM_TIMERS && armed_tbl[id] &&
                    tick_now >= deadline_tbl[id]) begin
                    deadline_tbl[id] = tick_now + TICK_W'(period_tbl[id]);
                    fired = 1'b1;
                end
            end
            default: ;
        endcase
        return fired;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] dly);
        int   gap;
        t_due want;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            i_action   <= ACT_W'($urandom);
            i_timer_id <= ID_W'($urandom);
            i_delay_ms <= PERIOD_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_timer_id <= id;
        i_delay_ms <= dly;
        do @(posedge i_clk); while (o_in_stall);
        want.action   = act;
        want.timer_id = id;
        want.expired  = advance_timers(act, id, dly);
        due_q.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int                  pick;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] dly;
        pick = $urandom_range(0, 99);
        // half the traffic on a few timers so they get polled often
        id  = $urandom_range(0, 1) ? ID_W'($urandom) : ID_W'($urandom_range(0, 3));
        dly = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom)
                                          : PERIOD_W'($urandom_range(0, 24));
        if (pick < 40)
            send_item(ACT_TICK, ID_W'($urandom), PERIOD_W'($urandom));
        else if (pick < 75)
            send_item(ACT_POLL, id, PERIOD_W'($urandom));
        else if (pick < 95)
            send_item(ACT_ARM, id, dly);
        else
            send_item(ACT_UNUSED, ID_W'($urandom), PERIOD_W'($urandom));
    endtask

    task automatic test_idle_codes();
        send_item(ACT_POLL, 4'd0, 16'h0000);     // unarmed after reset
        send_item(ACT_POLL, 4'd15, 16'hFFFF);
        send_item(ACT_UNUSED, 4'd15, 16'hFFFF);  // unused code changes nothing
        send_item(ACT_UNUSED, 4'd0, 16'h0000);
        send_item(ACT_TICK, 4'd15, 16'hFFFF);
        send_item(ACT_POLL, 4'd7, 16'h1234);
    endtask

    task automatic test_period_extremes();
        send_item(ACT_ARM, 4'd0, 16'h0000);      // zero period fires on every poll
        send_item(ACT_POLL, 4'd0, 16'h0000);
        send_item(ACT_POLL, 4'd0, 16'hFFFF);
        send_item(ACT_ARM, 4'd15, 16'hFFFF);
        send_item(ACT_POLL, 4'd15, 16'h0000);
        send_item(ACT_TICK, 4'd0, 16'h0000);
        send_item(ACT_POLL, 4'd15, 16'h0000);
        send_item(ACT_ARM, 4'd10, 16'hAAAA);
        send_item(ACT_ARM, 4'd10, 16'h5555);     // re-arm overwrites
        send_item(ACT_POLL, 4'd10, 16'hAAAA);
    endtask

    task automatic test_periodic_rearm();
        send_item(ACT_ARM, 4'd5, 16'd1);
        send_item(ACT_POLL, 4'd5, 16'd0);
        send_item(ACT_TICK, 4'd0, 16'd0);
        send_item(ACT_POLL, 4'd5, 16'd0);        // due now
        send_item(ACT_POLL, 4'd5, 16'd0);        // re-armed, not due
        send_item(ACT_TICK, 4'd0, 16'd0);
        send_item(ACT_POLL, 4'd5, 16'd0);
        send_item(ACT_POLL, 4'd0, 16'd0);
    endtask

    task automatic test_random_traffic(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_random_item();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_full_rate(input int count);
        no_gaps = 1'b1;
        for (int k = 0; k < count; k++)
            send_random_item();
        no_gaps = 1'b0;
    endtask

    task automatic test_noise(input int count);
        for (int k = 0; k < count; k++)
            send_item(ACT_W'($urandom), ID_W'($urandom), PERIOD_W'($urandom));
    endtask

    always @(posedge i_clk) begin
        t_due want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (due_q.size() == 0) begin
                note_error($sformatf("result expired=%b with nothing expected", o_expired));
            end else begin
                want = due_q.pop_front();
                if (o_expired !== want.expired)
                    note_error($sformatf("action %0d timer %0d: expired exp %b got %b",
                                         want.action, want.timer_id, want.expired,
                                         o_expired));
            end
        end
    end

    // output stall: a fresh wait drawn after each taken result
    always @(negedge i_clk) begin
        if (results_seen != stall_drawn_at) begin
            stall_drawn_at = results_seen;
            rx_wait = no_gaps ? 0 : $urandom_range(0, 15);
        end
        i_out_stall <= (rx_wait != 0);
        if (rx_wait != 0)
            rx_wait--;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_run = 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_run++;
        end
    end

    initial begin
        clear_timers();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_codes();
        test_period_extremes();
        test_periodic_rearm();
        test_random_traffic(1100);
        test_full_rate(400);
        test_noise(100);

        i_in_valid <= 1'b0;
        while (due_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
src/pstt_pkg.sv
src/pstt_table.sv
src/pstt_eval.sv
src/periodic_soft_timer_table_top.sv
verif/tb.sv
